// ===== design/endpoint_set_table_assert.svh =====
// Assertion macros shared by the endpoint set table.
`ifndef ENDPOINT_SET_TABLE_ASSERT_SVH
`define ENDPOINT_SET_TABLE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define EST_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("endpoint set table: invariant violated");

// A trigger that must be followed by a consequence on the next edge.
`define EST_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("endpoint set table: sequence violated");

`endif

// ===== design/est_pkg.sv =====
`timescale 1ns / 1ps

package est_pkg;

  localparam int unsigned ENTRIES_DEFAULT = 16;
  localparam int unsigned COUNT_OUT_W = 5;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_ABSENT  = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port_num;
  } req_t;

  typedef struct packed {
    logic                   found;
    logic [1:0]             status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [63:0] addr_high;
    logic [63:0] addr_low;
    logic [15:0] port_num;
  } key_t;

  // Token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic active;
    logic apply;
    logic hit;
    logic placed;
  } token_t;

endpackage

// ===== design/est_cell.sv =====
`timescale 1ns / 1ps

module est_cell import est_pkg::*; #(
  parameter int unsigned CntW = 5
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [1:0]      op_i,
  input  key_t            key_i,
  input  token_t          tok_i,
  input  logic [CntW-1:0] cnt_i,
  output token_t          tok_o,
  output logic [CntW-1:0] cnt_o
);

  logic            valid_q, valid_d;
  key_t            key_q;
  logic            write_en;
  token_t          tok_d, tok_q;
  logic [CntW-1:0] cnt_d, cnt_q;
  logic            match;

  assign match = valid_q && (key_q == key_i);

  always_comb begin
    tok_d    = tok_i;
    valid_d  = valid_q;
    write_en = 1'b0;
    cnt_d    = cnt_i;
    if (tok_i.active && !tok_i.apply) begin
      tok_d.hit = tok_i.hit | match;
    end else if (tok_i.active) begin
      if (op_i == OP_DELETE && tok_i.hit && match) begin
        valid_d = 1'b0;
      end
      if (op_i == OP_INSERT && !tok_i.hit && !tok_i.placed && !valid_q) begin
        valid_d      = 1'b1;
        write_en     = 1'b1;
        tok_d.placed = 1'b1;
      end
      cnt_d = cnt_i + CntW'(valid_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    if (write_en) begin
      key_q <= key_i;
    end
  end

  assign tok_o = tok_q;
  assign cnt_o = cnt_q;

endmodule

// ===== design/endpoint_set_table.sv =====
`timescale 1ns / 1ps
// Endpoint set table: a bounded set of endpoints, each a 128-bit address and a 16-bit port.
// Command channel: an item (op, address, port) is accepted at a rising edge where start_i
// is high and busy_o is low. Op lookup reports presence, insert adds the key to the
// lowest free slot if it is absent, delete clears every matching entry.
// Result channel: result_valid_o is high for exactly one cycle with found, status and the
// entry count after the request. The receiver cannot stall; it must take the item then.
// Each entry lives in its own cell, and the cells form a chain. A token carrying the
// request flags moves one cell per cycle: a first pass gathers the match flag, a second
// pass applies the insert or delete and counts the valid entries.
// Busy time: busy_o stays high from acceptance until the result strobe, which follows
// the end of the apply pass; the next item can be taken at the edge that ends the result
// cycle, so a new item is taken only once the last one is through. The busy time is set
// by the two walks of the token along the cell chain.
// Reset clears every valid bit at once, so the table starts empty; the stored keys keep
// no reset value and are never compared while invalid.
`include "endpoint_set_table_assert.svh"

module endpoint_set_table import est_pkg::*; #(
  parameter int unsigned ENTRIES = ENTRIES_DEFAULT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic result_valid_o,
  output rsp_t result_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_e;

  state_e      state_q;
  logic        inj_q;
  logic        hit_q;
  logic [1:0]  op_q;
  key_t        key_q;
  logic        result_valid_q;
  rsp_t        result_q;

  token_t          tok [ENTRIES+1];
  logic [CntW-1:0] cnt [ENTRIES+1];
  logic [ENTRIES-1:0] tok_active;

  token_t tok_last;
  logic [CntW+COUNT_OUT_W-1:0] cnt_wide;
  logic [1:0] status_d;

  // The injected token starts every pass at the head of the chain.
  assign tok[0] = '{active: inj_q, apply: (state_q == S_APPLY), hit: hit_q, placed: 1'b0};
  assign cnt[0] = '0;

  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    est_cell #(
      .CntW(CntW)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .op_i  (op_q),
      .key_i (key_q),
      .tok_i (tok[g]),
      .cnt_i (cnt[g]),
      .tok_o (tok[g+1]),
      .cnt_o (cnt[g+1])
    );
    assign tok_active[g] = tok[g+1].active;
  end

  assign tok_last = tok[ENTRIES];
  assign cnt_wide = {{COUNT_OUT_W{1'b0}}, cnt[ENTRIES]};

  // Status of the finished request, from the global hit and the placement flag.
  always_comb begin
    case (op_q)
      OP_INSERT: begin
        if (hit_q) begin
          status_d = ST_PRESENT;
        end else if (tok_last.placed) begin
          status_d = ST_DONE;
        end else begin
          status_d = ST_FULL;
        end
      end
      OP_DELETE: begin
        status_d = hit_q ? ST_DONE : ST_ABSENT;
      end
      default: begin
        status_d = ST_DONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      inj_q          <= 1'b0;
      hit_q          <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      inj_q          <= 1'b0;
      result_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_SCAN;
            inj_q   <= 1'b1;
            hit_q   <= 1'b0;
          end
        end
        S_SCAN: begin
          if (tok_last.active) begin
            state_q <= S_APPLY;
            inj_q   <= 1'b1;
            hit_q   <= tok_last.hit;
          end
        end
        S_APPLY: begin
          if (tok_last.active) begin
            state_q        <= S_IDLE;
            result_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      op_q            <= req_i.op;
      key_q.addr_high <= req_i.addr_high;
      key_q.addr_low  <= req_i.addr_low;
      key_q.port_num  <= req_i.port_num;
    end
    if (state_q == S_APPLY && tok_last.active) begin
      result_q.found       <= hit_q;
      result_q.status      <= status_d;
      result_q.entry_count <= cnt_wide[COUNT_OUT_W-1:0];
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  // Only one token may be in flight along the chain.
  `EST_ASSERT_ALWAYS(a_single_token, $onehot0(tok_active))
  // The end of the apply pass always yields a result strobe.
  `EST_ASSERT_NEXT(a_apply_gives_result, tok_last.active && tok_last.apply, result_valid_o)
  // A result is shown only once the block is free again.
  `EST_ASSERT_ALWAYS(a_result_not_busy, !result_valid_o || !busy_o)
  // A key that was present can be neither dropped for lack of room nor absent.
  `EST_ASSERT_ALWAYS(a_found_status,
      !(result_valid_o && result_o.found &&
        (result_o.status == ST_FULL || result_o.status == ST_ABSENT)))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import est_pkg::*;

  // The table size used here; the block is built with the same value.
  localparam int unsigned SLOTS = ENTRIES_DEFAULT;
  // The fourth op code has no name in the package. The block treats it as a lookup.
  localparam logic [1:0] OP_SPARE = 2'd3;
  // Cycles that the block spends on one item, from acceptance to the result strobe.
  localparam int unsigned ITEM_CYCLES = 2 * SLOTS + 2;
  // A quiet stretch this long means the block has hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_ITEMS = 425;
  localparam int unsigned POOL_SIZE = 24;

  // Shadow copy of the endpoint table. It predicts the response for each accepted
  // request and holds the predictions in order until the block delivers them.
  class endpoint_table_scoreboard;
    bit    slot_used[SLOTS];
    key_t  slot_key[SLOTS];
    rsp_t  pending_rsp_q[$];
    int    mismatches;
    int    requests_seen;
    int    responses_seen;
    int    hits;
    int    dropped_full;
    int    dup_inserts;
    int    absent_deletes;

    function void note_request(req_t r);
      key_t        k;
      bit          hit;
      bit          have_free;
      int unsigned free_slot;
      int unsigned used;
      rsp_t        rsp;
      k = '{addr_high: r.addr_high, addr_low: r.addr_low, port_num: r.port_num};
      hit = 1'b0;
      have_free = 1'b0;
      free_slot = 0;
      for (int unsigned i = 0; i < SLOTS; i++) begin
        if (slot_used[i] && slot_key[i] == k) hit = 1'b1;
        if (!slot_used[i] && !have_free) begin
          have_free = 1'b1;
          free_slot = i;
        end
      end
      rsp.status = ST_DONE;
      case (r.op)
        OP_INSERT: begin
          if (hit) begin
            rsp.status = ST_PRESENT;
          end else if (!have_free) begin
            rsp.status = ST_FULL;
          end else begin
            slot_used[free_slot] = 1'b1;
            slot_key[free_slot] = k;
          end
        end
        OP_DELETE: begin
          // Every matching entry goes, although inserts never create duplicates.
          if (hit) begin
            for (int unsigned i = 0; i < SLOTS; i++)
              if (slot_used[i] && slot_key[i] == k) slot_used[i] = 1'b0;
          end else begin
            rsp.status = ST_ABSENT;
          end
        end
        default: ;
      endcase
      used = 0;
      for (int unsigned i = 0; i < SLOTS; i++) used += slot_used[i];
      rsp.found = hit;
      rsp.entry_count = used[COUNT_OUT_W-1:0];
      pending_rsp_q.push_back(rsp);
      requests_seen++;
      hits += hit;
      dropped_full += (rsp.status == ST_FULL);
      dup_inserts += (rsp.status == ST_PRESENT);
      absent_deletes += (rsp.status == ST_ABSENT);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      responses_seen++;
      if (pending_rsp_q.size() == 0) begin
        $error("response with nothing outstanding: found %0d status %0d count %0d",
               got.found, got.status, got.entry_count);
        mismatches++;
        return;
      end
      want = pending_rsp_q.pop_front();
      if (got.found !== want.found) begin
        $error("found: expected %0d, got %0d", want.found, got.found);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic result_valid_o;
  rsp_t result_o;

  endpoint_table_scoreboard sb;
  key_t key_pool[POOL_SIZE];
  int unsigned quiet_cycles;

  endpoint_set_table #(
    .ENTRIES(SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .req_i         (req_i),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Everything is sampled at the rising edge, where the inputs have been steady since the
  // falling edge before it. A request is noted before any response of the same edge is
  // checked, although with this latency the two can never belong together. The watchdog
  // counts edges at which neither a request nor a response moved.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_i && !busy_o) sb.note_request(req_i);
      if (result_valid_o) sb.check_response(result_o);
      if ((start_i && !busy_o) || result_valid_o) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Watchdog expired with %0d responses outstanding.",
                   sb.pending_rsp_q.size());
          $display("Simulation FAILED");
          $finish;
        end
      end
    end
  end

  function automatic key_t random_key();
    key_t k;
    k.addr_high = {$urandom, $urandom};
    k.addr_low = {$urandom, $urandom};
    k.port_num = 16'($urandom_range(16'hffff, 0));
    return k;
  endfunction

  // Mostly keys from a small pool, so that inserts hit, deletes find their entries and
  // the table fills. The rest are fresh keys or pool keys with a single bit flipped,
  // which must not match their neighbour.
  function automatic key_t pick_key();
    int unsigned roll;
    key_t k;
    roll = $urandom_range(99, 0);
    if (roll < 80) begin
      k = key_pool[$urandom_range(POOL_SIZE - 1, 0)];
    end else if (roll < 90) begin
      k = random_key();
    end else begin
      k = key_pool[$urandom_range(POOL_SIZE - 1, 0)];
      k[$urandom_range($bits(key_t) - 1, 0)] ^= 1'b1;
    end
    return k;
  endfunction

  // In a filling phase inserts dominate, in a draining phase deletes do.
  function automatic logic [1:0] pick_op(bit filling);
    int unsigned roll;
    roll = $urandom_range(99, 0);
    if (roll < 5) return OP_SPARE;
    if (roll < 25) return OP_LOOKUP;
    if (roll < 80) return filling ? OP_INSERT : OP_DELETE;
    return filling ? OP_DELETE : OP_INSERT;
  endfunction

  // Entered just after a falling edge. Holds start high until the block takes the item
  // and returns just after the following falling edge.
  task automatic send_request(input logic [1:0] op, input key_t k);
    req_t r;
    r.op = op;
    r.addr_high = k.addr_high;
    r.addr_low = k.addr_low;
    r.port_num = k.port_num;
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles != 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(negedge clk_i);
    end
  endtask

  initial begin
    key_t zero_key;
    key_t ones_key;
    key_t near_key;
    int unsigned sent;
    int unsigned burst;
    int unsigned gap;
    bit filling;

    sb = new;
    quiet_cycles = 0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    foreach (key_pool[i]) key_pool[i] = random_key();
    // Pairs of pool keys that differ only in the port or only in the low address.
    key_pool[1] = key_pool[0];
    key_pool[1].port_num = ~key_pool[0].port_num;
    key_pool[3] = key_pool[2];
    key_pool[3].addr_low[0] = ~key_pool[2].addr_low[0];

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: the empty table, the extreme keys, a repeated insert, the spare op
    // code, a key that differs only in its port, then a full table with a dropped insert
    // and a repeated insert while full, and finally a delete of a key that is gone.
    zero_key = '0;
    ones_key = '1;
    near_key = ones_key;
    near_key.port_num = 16'hfffe;
    send_request(OP_LOOKUP, zero_key);
    send_request(OP_DELETE, zero_key);
    send_request(OP_INSERT, zero_key);
    send_request(OP_INSERT, ones_key);
    send_request(OP_INSERT, zero_key);
    send_request(OP_LOOKUP, ones_key);
    send_request(OP_SPARE, ones_key);
    send_request(OP_SPARE, near_key);
    send_request(OP_LOOKUP, near_key);
    for (int unsigned i = 2; i < SLOTS; i++) send_request(OP_INSERT, random_key());
    send_request(OP_INSERT, near_key);
    send_request(OP_INSERT, zero_key);
    send_request(OP_DELETE, ones_key);
    send_request(OP_DELETE, ones_key);

    // Random part: bursts of requests with gaps long enough to land on every cycle of
    // the block's work, and about a quarter of the bursts run back to back.
    sent = 0;
    filling = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(8, 1);
      for (int unsigned b = 0; b < burst && sent < RANDOM_ITEMS; b++) begin
        send_request(pick_op(filling), pick_key());
        sent++;
        if (sent % 40 == 0) filling = !filling;
      end
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(ITEM_CYCLES + 6, 1);
      pause_sender(gap);
    end
    start_i <= 1'b0;

    while (sb.pending_rsp_q.size() != 0) @(posedge clk_i);
    // A spare spell in which any stray response would show up.
    repeat (ITEM_CYCLES + 8) @(posedge clk_i);

    $display("Ran %0d requests, %0d responses checked: %0d hits, %0d dropped on a full table,",
             sb.requests_seen, sb.responses_seen, sb.hits, sb.dropped_full);
    $display("%0d repeated inserts and %0d deletes of absent keys.",
             sb.dup_inserts, sb.absent_deletes);
    if (sb.mismatches == 0 && sb.pending_rsp_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
